### hw/rtl/tiny_cpu_execute_step_assert.svh
// Assertion macros shared by the tiny CPU execute step RTL.
`ifndef TINY_CPU_EXECUTE_STEP_ASSERT_SVH
`define TINY_CPU_EXECUTE_STEP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TCES_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define TCES_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/tces_pkg.sv
// Types, codes and microcode table of the tiny CPU execute step.
`default_nettype none

package tces_pkg;

    localparam logic [1:0] CMD_WR   = 2'd0;
    localparam logic [1:0] CMD_RD   = 2'd1;
    localparam logic [1:0] CMD_EXEC = 2'd2;
    localparam logic [1:0] CMD_RST  = 2'd3;

    localparam logic [3:0] OPC_LOAD  = 4'h1;
    localparam logic [3:0] OPC_ADD   = 4'h2;
    localparam logic [3:0] OPC_SUB   = 4'h3;
    localparam logic [3:0] OPC_STORE = 4'h4;
    localparam logic [3:0] OPC_AND   = 4'h5;
    localparam logic [3:0] OPC_OR    = 4'h6;
    localparam logic [3:0] OPC_JMP   = 4'h7;
    localparam logic [3:0] OPC_HALT  = 4'hF;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  mem_addr;
        logic [15:0] mem_data;
    } t_in;

    typedef struct packed {
        logic [15:0] read_data;
        logic [7:0]  pc_after;
        logic [1:0]  status;
        logic [15:0] written_value;
    } t_out;

    // Microprogram addresses
    typedef enum logic [3:0] {
        U_IDLE, U_WR, U_RD, U_RD2, U_RST, U_EX, U_FETCH, U_DEC,
        U_LD, U_ST, U_ALU_B, U_ALU, U_JMP, U_HLT, U_BAD, U_REFUSE
    } t_upc;

    typedef enum logic [2:0] {BR_NEXT, BR_RUN, BR_OPC, BR_DONE} t_br;
    typedef enum logic [1:0] {A_IN, A_PC, A_MA} t_asel;
    typedef enum logic {W_IN, W_A} t_wsel;
    typedef enum logic [1:0] {RF_NONE, RF_LOAD, RF_ALU} t_rfw;
    typedef enum logic [1:0] {PC_KEEP, PC_INC, PC_ZERO, PC_JMP} t_pcop;
    typedef enum logic [1:0] {RUN_KEEP, RUN_SET, RUN_CLR} t_runop;
    typedef enum logic [2:0] {RES_NONE, RES_RD, RES_LOAD, RES_STORE, RES_ALU} t_res;

    typedef struct packed {
        t_upc       nxt;
        t_br        br;
        logic       mem_rd;
        logic       mem_wr;
        t_asel      asel;
        t_wsel      wsel;
        logic       ir_ld;
        logic       a_ld;
        logic       b_ld;
        t_rfw       rfw;
        t_pcop      pc_op;
        t_runop     run_op;
        t_res       res;
        logic [1:0] st;
    } t_cw;

    function automatic t_cw ucode(input t_upc u);
        t_cw cw;
        cw.nxt    = U_IDLE;
        cw.br     = BR_DONE;
        cw.mem_rd = 1'b0;
        cw.mem_wr = 1'b0;
        cw.asel   = A_IN;
        cw.wsel   = W_IN;
        cw.ir_ld  = 1'b0;
        cw.a_ld   = 1'b0;
        cw.b_ld   = 1'b0;
        cw.rfw    = RF_NONE;
        cw.pc_op  = PC_KEEP;
        cw.run_op = RUN_KEEP;
        cw.res    = RES_NONE;
        cw.st     = ST_OK;
        case (u)
            U_IDLE: begin
                cw.br = BR_NEXT;
            end
            U_WR: begin
                cw.mem_wr = 1'b1;
            end
            U_RD: begin
                cw.mem_rd = 1'b1;
                cw.br     = BR_NEXT;
                cw.nxt    = U_RD2;
            end
            U_RD2: begin
                cw.res = RES_RD;
            end
            U_RST: begin
                cw.pc_op  = PC_ZERO;
                cw.run_op = RUN_SET;
            end
            U_EX: begin
                // fetch issued speculatively; refused path ignores it
                cw.mem_rd = 1'b1;
                cw.asel   = A_PC;
                cw.br     = BR_RUN;
                cw.nxt    = U_FETCH;
            end
            U_FETCH: begin
                cw.ir_ld = 1'b1;
                cw.br    = BR_NEXT;
                cw.nxt   = U_DEC;
            end
            U_DEC: begin
                cw.a_ld   = 1'b1;
                cw.mem_rd = 1'b1;
                cw.asel   = A_MA;
                cw.br     = BR_OPC;
            end
            U_LD: begin
                cw.rfw   = RF_LOAD;
                cw.res   = RES_LOAD;
                cw.pc_op = PC_INC;
            end
            U_ST: begin
                cw.mem_wr = 1'b1;
                cw.asel   = A_MA;
                cw.wsel   = W_A;
                cw.res    = RES_STORE;
                cw.pc_op  = PC_INC;
            end
            U_ALU_B: begin
                cw.b_ld = 1'b1;
                cw.br   = BR_NEXT;
                cw.nxt  = U_ALU;
            end
            U_ALU: begin
                cw.rfw   = RF_ALU;
                cw.res   = RES_ALU;
                cw.pc_op = PC_INC;
            end
            U_JMP: begin
                cw.pc_op = PC_JMP;
            end
            U_HLT: begin
                cw.run_op = RUN_CLR;
                cw.pc_op  = PC_INC;
                cw.st     = ST_HALT;
            end
            U_BAD: begin
                cw.run_op = RUN_CLR;
                cw.pc_op  = PC_INC;
                cw.st     = ST_BAD;
            end
            U_REFUSE: begin
                cw.st = ST_REFUSED;
            end
            default: begin
                cw.br = BR_DONE;
            end
        endcase
        return cw;
    endfunction

    function automatic t_upc cmd_entry(input logic [1:0] cmd);
        case (cmd)
            CMD_WR:   return U_WR;
            CMD_RD:   return U_RD;
            CMD_EXEC: return U_EX;
            default:  return U_RST;
        endcase
    endfunction

    function automatic t_upc opc_entry(input logic [3:0] opc);
        case (opc) inside
            OPC_LOAD:                           return U_LD;
            OPC_STORE:                          return U_ST;
            OPC_ADD, OPC_SUB, OPC_AND, OPC_OR:  return U_ALU_B;
            OPC_JMP:                            return U_JMP;
            OPC_HALT:                           return U_HLT;
            default:                            return U_BAD;
        endcase
    endfunction

    function automatic logic [15:0] alu(input logic [3:0] opc, input logic [15:0] a,
                                        input logic [15:0] b);
        case (opc)
            OPC_ADD: return a + b;
            OPC_SUB: return a - b;
            OPC_AND: return a & b;
            default: return a | b;
        endcase
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tiny_cpu_execute_step.sv
// Tiny 16-bit CPU stepped one command word at a time, microcoded control.
`default_nettype none

// One input word is taken only while the sequencer is idle; each word runs a
// short microprogram, one control word per clock while the final step is not
// held, against a 16-bit datapath with a single-port main memory whose read
// data is registered. ADD, SUB, AND and OR read their two register operands
// in separate steps. A finished result sits in the output register while the
// next word is accepted; the final step waits only if that register is still
// full and the receiver stalls. Memory contents read as zero until written
// (one valid flip-flop per word).

`include "tiny_cpu_execute_step_assert.svh"

module tiny_cpu_execute_step
    import tces_pkg::*;
#(
    parameter int MEM_WORDS = 256,
    parameter int REG_COUNT = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [8:0] MEM_LIM = 9'(MEM_WORDS);

    t_upc             r_upc, n_upc;
    logic [7:0]       r_pc, n_pc;
    logic             r_run, n_run;
    logic             r_out_valid;
    t_out             r_out, n_out;
    t_in              r_in;
    logic [15:0]      r_ir;
    logic [15:0]      r_a;
    logic [15:0]      r_b;
    logic [15:0]      r_rf [REG_COUNT];
    logic [MEM_WORDS-1:0] r_mem_vld;
    logic [15:0]      r_mem [MEM_WORDS];
    logic [15:0]      r_mem_q;
    logic             r_mem_qv;

    t_cw              cw;
    logic             done_blocked;
    logic             go;
    logic             done_go;
    logic             accept;
    logic [7:0]       m_addr;
    logic             m_in_range;
    logic [AW-1:0]    m_idx;
    logic [15:0]      m_wdata;
    logic             m_we;
    logic             m_re;
    logic [15:0]      mem_rdata;
    logic [15:0]      alu_y;
    logic [RIDX_W-1:0] ra_idx;
    logic [RIDX_W-1:0] rb_idx;
    logic [RIDX_W-1:0] rd_idx;

    assign cw           = ucode(r_upc);
    assign accept       = i_valid && !o_stall;
    assign done_blocked = (cw.br == BR_DONE) && r_out_valid && i_stall;
    assign go           = (r_upc != U_IDLE) && !done_blocked;
    assign done_go      = go && (cw.br == BR_DONE);

    assign ra_idx = RIDX_W'(r_ir[7:5]);
    assign rb_idx = RIDX_W'(r_ir[4:2]);
    assign rd_idx = RIDX_W'(r_ir[1:0]);

    always_comb begin
        case (cw.asel)
            A_IN:    m_addr = r_in.mem_addr;
            A_PC:    m_addr = r_pc;
            default: m_addr = {3'b000, r_ir[4:0]};
        endcase
    end

    assign m_in_range = {1'b0, m_addr} < MEM_LIM;
    assign m_idx      = m_addr[AW-1:0];
    assign m_wdata    = (cw.wsel == W_A) ? r_a : r_in.mem_data;
    assign m_we       = go && cw.mem_wr && m_in_range;
    assign m_re       = go && cw.mem_rd;
    assign mem_rdata  = r_mem_qv ? r_mem_q : 16'h0000;
    assign alu_y      = alu(r_ir[11:8], r_a, r_b);

    // Next state of sequencer, pc, run flag and result word
    always_comb begin
        n_upc = r_upc;
        if (r_upc == U_IDLE) begin
            if (i_valid) begin
                n_upc = cmd_entry(i_data.cmd);
            end
        end else if (go) begin
            case (cw.br)
                BR_NEXT: n_upc = cw.nxt;
                BR_RUN:  n_upc = r_run ? cw.nxt : U_REFUSE;
                BR_OPC:  n_upc = opc_entry(r_ir[11:8]);
                default: n_upc = U_IDLE;
            endcase
        end

        case (cw.pc_op)
            PC_INC:  n_pc = r_pc + 8'd1;
            PC_ZERO: n_pc = 8'd0;
            PC_JMP:  n_pc = r_ir[7:0];
            default: n_pc = r_pc;
        endcase

        case (cw.run_op)
            RUN_SET: n_run = 1'b1;
            RUN_CLR: n_run = 1'b0;
            default: n_run = r_run;
        endcase

        n_out.read_data     = 16'h0000;
        n_out.written_value = 16'h0000;
        n_out.pc_after      = n_pc;
        n_out.status        = cw.st;
        case (cw.res)
            RES_RD:    n_out.read_data     = mem_rdata;
            RES_LOAD:  n_out.written_value = mem_rdata;
            RES_STORE: n_out.written_value = r_a;
            RES_ALU:   n_out.written_value = alu_y;
            default:   n_out.written_value = 16'h0000;
        endcase
    end

    // Control state, register file, valid bits and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= U_IDLE;
            r_pc        <= 8'd0;
            r_run       <= 1'b1;
            r_out_valid <= 1'b0;
            r_mem_vld   <= '0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_rf[i] <= 16'h0000;
            end
        end else begin
            r_upc <= n_upc;
            if (go) begin
                r_pc  <= n_pc;
                r_run <= n_run;
                case (cw.rfw)
                    RF_LOAD: r_rf[ra_idx] <= mem_rdata;
                    RF_ALU:  r_rf[rd_idx] <= alu_y;
                    default: ;
                endcase
            end
            if (m_we) begin
                r_mem_vld[m_idx] <= 1'b1;
            end
            if (done_go) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
        if (go && cw.ir_ld) begin
            r_ir <= mem_rdata;
        end
        if (go && cw.a_ld) begin
            r_a <= r_rf[ra_idx];
        end
        if (go && cw.b_ld) begin
            r_b <= r_rf[rb_idx];
        end
    end

    // Main memory, registered read
    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mem[m_idx] <= m_wdata;
        end
        if (m_re) begin
            r_mem_q  <= r_mem[m_idx];
            r_mem_qv <= m_in_range && r_mem_vld[m_idx];
        end
    end

    assign o_stall = (r_upc != U_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `TCES_ASSERT_NEXT(a_accept_leaves_idle, accept, o_stall, "sequencer stayed idle after accept")
    `TCES_ASSERT_NEXT(a_done_sets_valid, done_go, o_valid, "final step gave no result word")
    `TCES_ASSERT_NOW(a_refuse_only_stopped, done_go && (cw.st == ST_REFUSED), !r_run,
                     "step refused while running")
    `TCES_ASSERT_NEXT(a_blocked_holds_step, done_blocked, r_upc == $past(r_upc),
                      "final step moved while result register full")

endmodule

`default_nettype wire

### tb/tiny_cpu_execute_step_tb.sv
// Self-checking testbench for the tiny CPU execute step: directed rows, then random programs.
`timescale 1ns / 1ps

module tiny_cpu_execute_step_tb
    import tces_pkg::*;
();

    localparam int RAND_ITEMS  = 700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [3:0] ALU_OPS [4] = '{OPC_ADD, OPC_SUB, OPC_AND, OPC_OR};

    typedef struct packed {
        t_in  word;
        logic typed;
        t_out result;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_data  = '0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    // shadow copy of the machine
    logic [15:0] model_mem [256];
    logic [15:0] model_reg [8];
    logic [7:0]  model_pc;
    logic        model_run;

    t_out pending_results [$];
    t_out want_res;
    t_dir_row dir_rows [$];

    int err_cnt       = 0;
    int rand_cnt      = 0;
    int cycle_cnt     = 0;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_left     = 0;

    tiny_cpu_execute_step dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out cpu_step(input t_in w);
        t_out        r;
        logic [15:0] instr;
        logic [3:0]  opc;
        logic [7:0]  opd;
        logic [2:0]  ra;
        logic [2:0]  rb;
        r = '0;
        case (w.cmd)
            CMD_WR: model_mem[w.mem_addr] = w.mem_data;
            CMD_RD: r.read_data = model_mem[w.mem_addr];
            CMD_RST: begin
                model_pc  = '0;
                model_run = 1'b1;
            end
            default: begin
                if (!model_run) begin
                    r.status = ST_REFUSED;
                end else begin
                    instr = model_mem[model_pc];
                    opc   = instr[11:8];
                    opd   = instr[7:0];
                    ra    = opd[7:5];
                    rb    = opd[4:2];
                    case (opc)
                        OPC_LOAD: begin
                            r.written_value = model_mem[opd[4:0]];
                            model_reg[ra]   = r.written_value;
                        end
                        OPC_STORE: begin
                            r.written_value     = model_reg[ra];
                            model_mem[opd[4:0]] = r.written_value;
                        end
                        OPC_ADD, OPC_SUB, OPC_AND, OPC_OR: begin
                            case (opc)
                                OPC_ADD: r.written_value = model_reg[ra] + model_reg[rb];
                                OPC_SUB: r.written_value = model_reg[ra] - model_reg[rb];
                                OPC_AND: r.written_value = model_reg[ra] & model_reg[rb];
                                default: r.written_value = model_reg[ra] | model_reg[rb];
                            endcase
                            // destination field is only two bits: R0..R3
                            model_reg[opd[1:0]] = r.written_value;
                        end
                        OPC_JMP: ;
                        OPC_HALT: begin
                            model_run = 1'b0;
                            r.status  = ST_HALT;
                        end
                        default: begin
                            model_run = 1'b0;
                            r.status  = ST_BAD;
                        end
                    endcase
                    model_pc = (opc == OPC_JMP) ? opd : model_pc + 8'd1;
                end
            end
        endcase
        r.pc_after = model_pc;
        return r;
    endfunction

    function automatic t_dir_row plain_row(input logic [1:0] cmd, input logic [7:0] addr,
                                           input logic [15:0] data);
        t_dir_row r;
        r = '0;
        r.word.cmd      = cmd;
        r.word.mem_addr = addr;
        r.word.mem_data = data;
        return r;
    endfunction

    function automatic t_dir_row known_row(input logic [1:0] cmd, input logic [7:0] addr,
                                           input logic [15:0] data, input logic [15:0] rd,
                                           input logic [7:0] pc, input logic [1:0] st);
        t_dir_row r;
        r = plain_row(cmd, addr, data);
        r.typed            = 1'b1;
        r.result.read_data = rd;
        r.result.pc_after  = pc;
        r.result.status    = st;
        return r;
    endfunction

    // Random instruction; jumps mostly land inside the program just written.
    function automatic logic [15:0] rand_instr(input logic [7:0] base, input int len);
        logic [3:0] opc;
        logic [7:0] opd;
        int         pick;
        pick = $urandom_range(99);
        opd  = 8'($urandom_range(255));
        if (pick < 15) begin
            opc = OPC_LOAD;
        end else if (pick < 30) begin
            opc = OPC_STORE;
        end else if (pick < 70) begin
            opc = ALU_OPS[$urandom_range(3)];
        end else if (pick < 82) begin
            opc = OPC_JMP;
            if ($urandom_range(3) != 0)
                opd = 8'(base + $urandom_range(len - 1));
        end else if (pick < 92) begin
            opc = OPC_HALT;
        end else begin
            do opc = 4'($urandom_range(15));
            while (opc inside {OPC_LOAD, OPC_ADD, OPC_SUB, OPC_STORE, OPC_AND, OPC_OR,
                               OPC_JMP, OPC_HALT});
        end
        return {4'($urandom_range(15)), opc, opd};
    endfunction

    task automatic send_word(input t_in w, input logic typed, input t_out typed_res);
        t_out pred;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
        pred = cpu_step(w);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic issue(input logic [1:0] cmd, input logic [7:0] addr, input logic [15:0] data);
        t_in w;
        w.cmd      = cmd;
        w.mem_addr = addr;
        w.mem_data = data;
        send_word(w, 1'b0, '0);
        rand_cnt++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                err_cnt++;
                $display("%0t: result word with nothing expected: rd=%h pc=%h st=%0d wv=%h",
                         $time, o_data.read_data, o_data.pc_after, o_data.status,
                         o_data.written_value);
            end else begin
                want_res = pending_results.pop_front();
                if (o_data !== want_res) begin
                    err_cnt++;
                    $display("%0t: expected rd/pc/st/wv %h/%h/%0d/%h, got %h/%h/%0d/%h",
                             $time, want_res.read_data, want_res.pc_after, want_res.status,
                             want_res.written_value, o_data.read_data, o_data.pc_after,
                             o_data.status, o_data.written_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stim
        int         cur_phase;
        int         nxt_phase;
        int         len;
        int         pick;
        logic [7:0] base;

        for (int i = 0; i < 256; i++) model_mem[i] = '0;
        for (int i = 0; i < 8; i++) model_reg[i] = '0;
        model_pc  = '0;
        model_run = 1'b1;

        // fresh memory and bad opcode at 0, then a program using every opcode
        dir_rows.push_back(known_row(CMD_RD,   8'h00, 16'h0000, 16'h0000, 8'h00, ST_OK));
        dir_rows.push_back(known_row(CMD_WR,   8'hFF, 16'hFFFF, 16'h0000, 8'h00, ST_OK));
        dir_rows.push_back(known_row(CMD_RD,   8'hFF, 16'h0000, 16'hFFFF, 8'h00, ST_OK));
        dir_rows.push_back(known_row(CMD_EXEC, 8'h00, 16'h0000, 16'h0000, 8'h01, ST_BAD));
        dir_rows.push_back(known_row(CMD_EXEC, 8'hFF, 16'hFFFF, 16'h0000, 8'h01, ST_REFUSED));
        dir_rows.push_back(plain_row(CMD_WR,   8'h1F, 16'h8001));
        dir_rows.push_back(plain_row(CMD_WR,   8'h1E, 16'hFFFF));
        dir_rows.push_back(plain_row(CMD_WR,   8'h00, 16'h013F));  // LOAD R1, [31]
        dir_rows.push_back(plain_row(CMD_WR,   8'h01, 16'h015E));  // LOAD R2, [30]
        dir_rows.push_back(plain_row(CMD_WR,   8'h02, 16'h022B));  // R3 = R1 + R2, wraps
        dir_rows.push_back(plain_row(CMD_WR,   8'h03, 16'h0328));  // R0 = R1 - R2
        dir_rows.push_back(plain_row(CMD_WR,   8'h04, 16'h0569));  // R1 = R3 & R2
        dir_rows.push_back(plain_row(CMD_WR,   8'h05, 16'h06E2));  // R2 = R7 | R0
        dir_rows.push_back(plain_row(CMD_WR,   8'h06, 16'h047C));  // STORE R3, [28]
        dir_rows.push_back(plain_row(CMD_WR,   8'h07, 16'hF7F0));  // JMP 0xF0, top bits set
        dir_rows.push_back(plain_row(CMD_WR,   8'hF0, 16'hAF00));  // HALT
        dir_rows.push_back(known_row(CMD_RST,  8'hA5, 16'h5A5A, 16'h0000, 8'h00, ST_OK));
        repeat (8) dir_rows.push_back(plain_row(CMD_EXEC, 8'h00, 16'h0000));
        dir_rows.push_back(known_row(CMD_EXEC, 8'h00, 16'h0000, 16'h0000, 8'hF1, ST_HALT));
        dir_rows.push_back(known_row(CMD_EXEC, 8'h00, 16'h0000, 16'h0000, 8'hF1, ST_REFUSED));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].result);
        drain_results();

        // long receiver hold while the sender keeps pushing
        hold_req++;
        cur_phase = 0;
        while (rand_cnt < RAND_ITEMS) begin
            nxt_phase = (rand_cnt * 4) / RAND_ITEMS;
            if (nxt_phase != cur_phase) begin
                cur_phase = nxt_phase;
                drain_results();
                case (cur_phase)
                    1: begin snd_idle_pct = 69; rcv_stall_pct = 0;  end
                    2: begin snd_idle_pct = 0;  rcv_stall_pct = 69; end
                    default: begin snd_idle_pct = 13; rcv_stall_pct = 13; end
                endcase
            end
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 4))
                    issue(2'($urandom_range(3)), 8'($urandom_range(255)), 16'($urandom));
            end else begin
                pick = $urandom_range(2);
                base = (pick == 0) ? 8'h00 :
                       (pick == 1) ? 8'($urandom_range(255)) : 8'($urandom_range(248, 255));
                len  = $urandom_range(2, 8);
                if (base != 8'h00)
                    issue(CMD_WR, 8'h00, {4'($urandom_range(15)), OPC_JMP, base});
                repeat ($urandom_range(0, 3))
                    issue(CMD_WR, 8'($urandom_range(31)), 16'($urandom));
                for (int i = 0; i < len; i++)
                    issue(CMD_WR, 8'(base + i), rand_instr(base, len));
                issue(CMD_RST, 8'($urandom_range(255)), 16'($urandom));
                repeat (len + $urandom_range(1, 4))
                    issue(CMD_EXEC, 8'($urandom_range(255)), 16'($urandom));
                if ($urandom_range(1) == 1)
                    issue(CMD_RD, 8'($urandom_range(31)), 16'($urandom));
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
